>>> rtl/core/lcdw_pkg.sv
// Types, codes and the power-on sequence table for the LCD write timing sequencer.
package lcdw_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CMD   = 2'd1,
    OP_DATA  = 2'd2,
    OP_START = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_STROBE = 2'd1,
    PH_SETTLE = 2'd2,
    PH_PAUSE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_ENABLE     = 2'd0,
    REG_SHORT_WAIT = 2'd1,
    REG_LONG_WAIT  = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  localparam int unsigned SEQ_LEN = 11;
  localparam logic [15:0] POWER_ON_WAIT = 16'd20000;
  localparam logic [7:0]  LONG_CMD_LIMIT = 8'd4;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic       rs_line;
    logic       enable_line;
    logic [7:0] data_lines;
    logic       busy_res;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  enable_ticks;
    logic [15:0] short_wait_ticks;
    logic [15:0] long_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic        is_wait;
    logic [15:0] amount;
  } seq_action_t;

  function automatic seq_action_t seq_action(input logic [3:0] step);
    seq_action_t a;
    case (step)
      4'd0:    a = '{1'b1, POWER_ON_WAIT};
      4'd1:    a = '{1'b0, 16'h0030};
      4'd2:    a = '{1'b1, 16'd5000};
      4'd3:    a = '{1'b0, 16'h0030};
      4'd4:    a = '{1'b1, 16'd100};
      4'd5:    a = '{1'b0, 16'h0030};
      4'd6:    a = '{1'b1, 16'd100};
      4'd7:    a = '{1'b0, 16'h0038};
      4'd8:    a = '{1'b0, 16'h0006};
      4'd9:    a = '{1'b0, 16'h0001};
      4'd10:   a = '{1'b0, 16'h000F};
      default: a = '{1'b0, 16'h0000};
    endcase
    return a;
  endfunction

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

>>> rtl/core/lcdw_seq.sv
// Phase, countdown and power-on step state, advanced once per accepted request.
module lcdw_seq import lcdw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] countdown_r, countdown_nxt;
  logic [3:0]  init_step_r, init_step_nxt;
  logic [7:0]  held_byte_r, held_byte_nxt;
  logic        held_select_r, held_select_nxt;
  logic        rej;
  logic [15:0] cd_dec;
  logic [15:0] enable_len;
  seq_action_t act;

  assign enable_len = at_least_one({8'd0, cfg.enable_ticks});
  assign cd_dec     = (countdown_r != 16'd0) ? countdown_r - 16'd1 : 16'd0;
  assign act        = seq_action(init_step_r);

  always_comb begin
    phase_nxt       = phase_r;
    countdown_nxt   = countdown_r;
    init_step_nxt   = init_step_r;
    held_byte_nxt   = held_byte_r;
    held_select_nxt = held_select_r;
    rej             = 1'b0;
    if (op_t'(item.operation) != OP_TICK && phase_r == PH_IDLE) begin
      case (op_t'(item.operation))
        OP_CMD, OP_DATA: begin
          held_byte_nxt   = item.byte_value;
          held_select_nxt = (op_t'(item.operation) == OP_DATA);
          phase_nxt       = PH_STROBE;
          countdown_nxt   = enable_len;
        end
        default: begin
          init_step_nxt = 4'd1;
          phase_nxt     = PH_PAUSE;
          countdown_nxt = POWER_ON_WAIT;
        end
      endcase
    end else begin
      rej = (op_t'(item.operation) != OP_TICK);
      if (phase_r != PH_IDLE) begin
        countdown_nxt = cd_dec;
        if (cd_dec == 16'd0) begin
          if (phase_r == PH_STROBE) begin
            phase_nxt = PH_SETTLE;
            if (!held_select_r && held_byte_r < LONG_CMD_LIMIT) begin
              countdown_nxt = at_least_one(cfg.long_wait_ticks);
            end else begin
              countdown_nxt = at_least_one(cfg.short_wait_ticks);
            end
          end else if (init_step_r == 4'd0 || init_step_r >= 4'(SEQ_LEN)) begin
            init_step_nxt = 4'd0;
            phase_nxt     = PH_IDLE;
            countdown_nxt = 16'd0;
          end else begin
            init_step_nxt = init_step_r + 4'd1;
            if (act.is_wait) begin
              phase_nxt     = PH_PAUSE;
              countdown_nxt = at_least_one(act.amount);
            end else begin
              held_byte_nxt   = act.amount[7:0];
              held_select_nxt = 1'b0;
              phase_nxt       = PH_STROBE;
              countdown_nxt   = enable_len;
            end
          end
        end
      end
    end
  end

  always_comb begin
    result.rs_line     = (phase_nxt == PH_STROBE) && held_select_nxt;
    result.enable_line = (phase_nxt == PH_STROBE);
    result.data_lines  = held_byte_nxt;
    result.busy_res    = (phase_nxt != PH_IDLE);
    result.rejected    = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      countdown_r   <= 16'd0;
      init_step_r   <= 4'd0;
      held_byte_r   <= 8'd0;
      held_select_r <= 1'b0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      countdown_r   <= countdown_nxt;
      init_step_r   <= init_step_nxt;
      held_byte_r   <= held_byte_nxt;
      held_select_r <= held_select_nxt;
    end
  end

endmodule

>>> rtl/core/lcd_write_timing_sequencer.sv
// Top level of the LCD write timing sequencer: configuration registers and output skid.
// Usage:
//   Each request on in_* is one microsecond tick, a command write, a data write or a
//   start of the power-on sequence (in_data.operation). Every request gives exactly one
//   result on out_* with the LCD pin levels after it, a busy flag and a rejected flag.
//   Requests other than ticks arriving while a write, its wait or the power-on sequence
//   runs are rejected and count as a tick.
//   cfg_we/cfg_index/cfg_data write enable width, short wait and long wait; write them
//   only while idle. Index 3 is ignored. Durations of zero act as one tick.
//   Results are registered, into the skid entry while the output register is held.
//   One request per cycle while in_stall is low; the step logic is one countdown update.
//   A two-entry output buffer lets a request be taken while one result waits; in_stall
//   rises only when both entries are full, so a stalling receiver holds the input off
//   after one extra result.
//   Reset (rst_n low, synchronous): idle, pins low, registers back to enable 1,
//   short wait 40, long wait 2000, output buffer empty.
module lcd_write_timing_sequencer import lcdw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t      cfg_r;
  out_item_t result;
  out_item_t out_data_r, skid_data_r;
  logic      out_valid_r, skid_valid_r;
  logic      in_fire, out_fire;

  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !skid_valid_r;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_ticks     <= 8'd1;
      cfg_r.short_wait_ticks <= 16'd40;
      cfg_r.long_wait_ticks  <= 16'd2000;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ENABLE:     cfg_r.enable_ticks     <= cfg_data[7:0];
        REG_SHORT_WAIT: cfg_r.short_wait_ticks <= cfg_data;
        REG_LONG_WAIT:  cfg_r.long_wait_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  lcdw_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_fire),
    .item    (in_data),
    .cfg     (cfg_r),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_data_r  <= result;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= result;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

>>> bench/tb_lcd_write_timing_sequencer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LCD write timing sequencer: predicted pin levels per request.
module tb_lcd_write_timing_sequencer import lcdw_pkg::*; ();

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  lcd_write_timing_sequencer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted bus state and registers
  phase_t      lcd_phase;
  logic [15:0] lcd_count;
  logic [3:0]  lcd_step;
  logic [7:0]  lcd_byte;
  logic        lcd_select;
  logic [7:0]  en_ticks;
  logic [15:0] short_ticks;
  logic [15:0] long_ticks;

  out_item_t   pins_due[$];
  out_item_t   pins_exp;
  int          mismatches;
  bit          steady;
  int unsigned hold_request;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("tb_lcd_write_timing_sequencer: errors");
    $finish;
  end

  function automatic logic [15:0] nonzero_ticks(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void start_write(input logic [7:0] b, input logic sel);
    lcd_byte   = b;
    lcd_select = sel;
    lcd_phase  = PH_STROBE;
    lcd_count  = nonzero_ticks({8'd0, en_ticks});
  endfunction

  function automatic void next_power_on_action();
    logic        pause;
    logic [15:0] amt;
    if (lcd_step == 4'd0 || lcd_step >= 4'(SEQ_LEN)) begin
      lcd_step  = 4'd0;
      lcd_phase = PH_IDLE;
      lcd_count = 16'd0;
      return;
    end
    pause = 1'b0;
    case (lcd_step)
      4'd2: begin
        pause = 1'b1;
        amt = 16'd5000;
      end
      4'd4, 4'd6: begin
        pause = 1'b1;
        amt = 16'd100;
      end
      4'd7:    amt = 16'h0038;
      4'd8:    amt = 16'h0006;
      4'd9:    amt = 16'h0001;
      4'd10:   amt = 16'h000F;
      default: amt = 16'h0030;
    endcase
    lcd_step = lcd_step + 4'd1;
    if (pause) begin
      lcd_phase = PH_PAUSE;
      lcd_count = amt;
    end else begin
      start_write(amt[7:0], 1'b0);
    end
  endfunction

  function automatic void tick_once();
    if (lcd_phase == PH_IDLE) return;
    if (lcd_count != 16'd0) lcd_count = lcd_count - 16'd1;
    if (lcd_count != 16'd0) return;
    if (lcd_phase == PH_STROBE) begin
      lcd_phase = PH_SETTLE;
      if (!lcd_select && lcd_byte < LONG_CMD_LIMIT) lcd_count = nonzero_ticks(long_ticks);
      else lcd_count = nonzero_ticks(short_ticks);
    end else begin
      next_power_on_action();
    end
  endfunction

  function automatic out_item_t predict_pins(input in_item_t r);
    out_item_t o;
    logic      rej;
    rej = 1'b0;
    if (r.operation != OP_TICK && lcd_phase == PH_IDLE) begin
      case (op_t'(r.operation))
        OP_CMD:  start_write(r.byte_value, 1'b0);
        OP_DATA: start_write(r.byte_value, 1'b1);
        default: begin
          lcd_step  = 4'd1;
          lcd_phase = PH_PAUSE;
          lcd_count = POWER_ON_WAIT;
        end
      endcase
    end else begin
      rej = (r.operation != OP_TICK);
      tick_once();
    end
    o.rs_line     = (lcd_phase == PH_STROBE) && lcd_select;
    o.enable_line = (lcd_phase == PH_STROBE);
    o.data_lines  = lcd_byte;
    o.busy_res    = (lcd_phase != PH_IDLE);
    o.rejected    = rej;
    return o;
  endfunction

  task automatic send_request(input in_item_t r);
    int unsigned gap;
    bit          taken;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    pins_due.push_back(predict_pins(r));
  endtask

  task automatic send_op(input op_t op, input logic [7:0] b);
    in_item_t r;
    r.operation  = op;
    r.byte_value = b;
    send_request(r);
  endtask

  task automatic run_until_idle(input bit noisy);
    op_t op;
    while (lcd_phase != PH_IDLE) begin
      op = OP_TICK;
      if (noisy && $urandom_range(0, 9) == 0) op = op_t'($urandom_range(1, 3));
      send_op(op, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_settled();
    in_valid <= 1'b0;
    do @(posedge clk); while (pins_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ENABLE:     en_ticks = val[7:0];
      REG_SHORT_WAIT: short_ticks = val;
      REG_LONG_WAIT:  long_ticks = val;
      default: ;
    endcase
  endtask

  task automatic test_directed_writes();
    send_op(OP_TICK, 8'h00);
    send_op(OP_CMD, 8'h00);
    send_op(OP_DATA, 8'hAA);
    send_op(OP_START, 8'hFF);
    send_op(OP_CMD, 8'h10);
    run_until_idle(1'b0);
    send_op(OP_CMD, 8'h03);
    run_until_idle(1'b0);
    send_op(OP_CMD, 8'h04);
    run_until_idle(1'b0);
    send_op(OP_CMD, 8'hFF);
    run_until_idle(1'b0);
    send_op(OP_DATA, 8'h00);
    run_until_idle(1'b0);
    send_op(OP_DATA, 8'hFF);
    run_until_idle(1'b0);
    send_op(OP_TICK, 8'hFF);
    wait_settled();
  endtask

  task automatic test_power_on();
    send_op(OP_START, 8'($urandom_range(0, 255)));
    run_until_idle(1'b1);
    send_op(OP_TICK, 8'h5A);
    wait_settled();
  endtask

  task automatic test_duration_extremes();
    steady = 1'b1;
    write_reg(REG_ENABLE, 16'hFF00);
    write_reg(REG_SHORT_WAIT, 16'd0);
    write_reg(REG_LONG_WAIT, 16'd0);
    send_op(OP_CMD, 8'h01);
    run_until_idle(1'b1);
    send_op(OP_DATA, 8'h41);
    run_until_idle(1'b1);
    wait_settled();
    write_reg(REG_ENABLE, 16'h00FF);
    write_reg(REG_SHORT_WAIT, 16'd1);
    write_reg(REG_LONG_WAIT, 16'hFFFF);
    send_op(OP_CMD, 8'h02);
    run_until_idle(1'b0);
    wait_settled();
    write_reg(REG_SHORT_WAIT, 16'hFFFF);
    write_reg(REG_LONG_WAIT, 16'd1);
    write_reg(REG_NONE, 16'h0000);
    send_op(OP_DATA, 8'h7E);
    run_until_idle(1'b0);
    wait_settled();
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    write_reg(REG_ENABLE, 16'd2);
    write_reg(REG_SHORT_WAIT, 16'd3);
    write_reg(REG_LONG_WAIT, 16'd5);
    steady = 1'b1;
    hold_request = 80;
    repeat (40) send_op(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 7)));
    steady = 1'b0;
    run_until_idle(1'b0);
    wait_settled();
  endtask

  task automatic test_random_traffic();
    int   n;
    op_t  op;
    logic [7:0] b;
    for (n = 0; n < 1950; n++) begin
      if (n % 245 == 0) begin
        run_until_idle(1'b0);
        wait_settled();
        if (n == 0) begin
          write_reg(REG_ENABLE, 16'd1);
          write_reg(REG_SHORT_WAIT, 16'd1);
          write_reg(REG_LONG_WAIT, 16'd1);
        end else begin
          write_reg(REG_ENABLE, {8'($urandom_range(0, 255)), 8'($urandom_range(0, 6))});
          write_reg(REG_SHORT_WAIT, 16'($urandom_range(0, 24)));
          write_reg(REG_LONG_WAIT, 16'($urandom_range(0, 48)));
        end
        if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, 16'($urandom_range(0, 65535)));
      end
      if (lcd_phase == PH_IDLE) begin
        case ($urandom_range(0, 9))
          0, 1:          op = OP_TICK;
          2, 3, 4, 5:    op = OP_CMD;
          default:       op = OP_DATA;
        endcase
      end else begin
        op = ($urandom_range(0, 99) < 85) ? OP_TICK : op_t'($urandom_range(1, 3));
      end
      b = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
      send_op(op, b);
    end
    run_until_idle(1'b0);
  endtask

  // receiver: random stalls, or a counted hold-off on request
  initial begin
    int unsigned len;
    out_stall <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        len = hold_request;
        hold_request = 0;
      end else if (steady) begin
        len = 0;
      end else begin
        len = pick_gap();
      end
      if (len != 0) begin
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (steady ? 1 : $urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pins_due.size() == 0) begin
        $error("result with no request pending");
        mismatches++;
      end else begin
        pins_exp = pins_due.pop_front();
        if (out_data.rs_line !== pins_exp.rs_line) begin
          $error("rs_line expected %0d got %0d", pins_exp.rs_line, out_data.rs_line);
          mismatches++;
        end
        if (out_data.enable_line !== pins_exp.enable_line) begin
          $error("enable_line expected %0d got %0d", pins_exp.enable_line,
                 out_data.enable_line);
          mismatches++;
        end
        if (out_data.data_lines !== pins_exp.data_lines) begin
          $error("data_lines expected %02h got %02h", pins_exp.data_lines,
                 out_data.data_lines);
          mismatches++;
        end
        if (out_data.busy_res !== pins_exp.busy_res) begin
          $error("busy_res expected %0d got %0d", pins_exp.busy_res, out_data.busy_res);
          mismatches++;
        end
        if (out_data.rejected !== pins_exp.rejected) begin
          $error("rejected expected %0d got %0d", pins_exp.rejected, out_data.rejected);
          mismatches++;
        end
      end
    end
  end

  initial begin
    mismatches   = 0;
    steady       = 1'b0;
    hold_request = 0;
    lcd_phase    = PH_IDLE;
    lcd_count    = 16'd0;
    lcd_step     = 4'd0;
    lcd_byte     = 8'd0;
    lcd_select   = 1'b0;
    en_ticks     = 8'd1;
    short_ticks  = 16'd40;
    long_ticks   = 16'd2000;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_ENABLE;
    cfg_data  <= 16'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_writes();
    test_power_on();
    test_duration_extremes();
    test_backpressure();
    test_random_traffic();
    wait_settled();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pins_due.size() == 0) begin
      $display("tb_lcd_write_timing_sequencer: clean");
    end else begin
      $display("tb_lcd_write_timing_sequencer: errors");
    end
    $finish;
  end

endmodule
